>>> rtl/pcr_pkg.sv
package pcr_pkg;

   // Component format and fixed field widths.
   localparam int CW = 21;
   localparam int FB = 10;
   localparam int VW = 3 * CW;
   localparam int MW = 20;
   localparam int RW = 11;
   localparam int TW = MW + 1;

   // Intermediate widths, derived from the field widths above; PER_W is fixed at 32.
   localparam int DOT_W = 2 * CW + 3;
   localparam int SEP_W = DOT_W - FB;
   localparam int ACP_W = SEP_W + MW + 1;
   localparam int ACC_W = ACP_W - FB;
   localparam int TGT_W = SEP_W + RW - FB;
   localparam int RAD_W = ACC_W + RW + 1 - FB;
   localparam int NUM_W = TGT_W + 1;
   localparam int DVD_W = NUM_W + FB;
   localparam int DIV_STEPS = DVD_W;
   localparam int PER_W = 32;
   localparam int IMP_W = PER_W + FB - 1;
   localparam int MPI_W = MW + FB + 1;
   localparam int PRV_W = CW + IMP_W + 1;
   localparam int PRP_W = CW + MPI_W + 1;
   localparam int DEL_W = PER_W + MW + 1;

   // Six front stages, the divider input stage, the divider steps, five back stages.
   localparam int NUM_STAGES = 7 + DIV_STEPS + 5;

   localparam logic signed [63:0] CMAX64 = (64'sd1 <<< (CW - 1)) - 64'sd1;
   localparam logic signed [63:0] CMIN64 = -CMAX64 - 64'sd1;
   localparam logic signed [63:0] PMAX64 = (64'sd1 <<< (PER_W - 1)) - 64'sd1;
   localparam logic signed [63:0] PMIN64 = -PMAX64 - 64'sd1;

   typedef logic [VW-1:0]          vec_type;
   typedef logic signed [CW-1:0]   comp_type;
   typedef logic [MW-1:0]          mass_type;
   typedef logic signed [PER_W-1:0] per_type;

   typedef struct packed {
      vec_type  vel_a;
      vec_type  vel_b;
      vec_type  pos_a;
      vec_type  pos_b;
      vec_type  normal;
      mass_type inv_mass_a;
      mass_type inv_mass_b;
      logic     has_b;
      logic     vel_chg;
      logic     pos_chg;
      comp_type sep_sat;
   } carry_type;

   typedef struct {
      carry_type           car;
      logic signed [CW:0]  rv [3];
      logic signed [CW:0]  ra [3];
      logic [TW-1:0]       tot;
      logic [RW-1:0]       rest;
      comp_type            pen;
   } s1_type;

   typedef struct {
      carry_type             car;
      logic signed [2*CW:0]  pv [3];
      logic signed [2*CW:0]  pq [3];
      logic [TW-1:0]         tot;
      logic [RW-1:0]         rest;
      comp_type              pen;
   } s2_type;

   typedef struct {
      carry_type              car;
      logic signed [SEP_W-1:0] sep;
      logic signed [SEP_W-1:0] dota;
      logic [TW-1:0]          tot;
      logic [RW-1:0]          rest;
      comp_type               pen;
   } s3_type;

   typedef struct {
      carry_type               car;
      logic signed [SEP_W-1:0] sep;
      logic signed [ACP_W-1:0] acc_prod;
      logic [TGT_W-1:0]        tgt0;
      logic [TW-1:0]           tot;
      logic [RW-1:0]           rest;
      comp_type                pen;
   } s4_type;

   typedef struct {
      carry_type               car;
      logic signed [SEP_W-1:0] sep;
      logic signed [ACC_W-1:0] accsep;
      logic [TGT_W-1:0]        tgt0;
      logic [TW-1:0]           tot;
      logic [RW-1:0]           rest;
      comp_type                pen;
   } s5_type;

   typedef struct {
      carry_type               car;
      logic signed [SEP_W-1:0] sep;
      logic                    accneg;
      logic signed [RAD_W-1:0] radd;
      logic [TGT_W-1:0]        tgt0;
      logic [TW-1:0]           tot;
      comp_type                pen;
   } s6_type;

   typedef struct {
      carry_type        car;
      logic [TW-1:0]    tot;
      logic [TW-1:0]    rem_v;
      logic [TW-1:0]    rem_p;
      logic [DVD_W-1:0] dq_v;
      logic [DVD_W-1:0] dq_p;
   } div_type;

   typedef struct {
      carry_type        car;
      logic [IMP_W-1:0] imp;
      logic [MPI_W-1:0] mpi;
   } p1_type;

   typedef struct {
      carry_type               car;
      logic signed [PRV_W-1:0] prv [3];
      logic signed [PRP_W-1:0] prp [3];
   } p2_type;

   typedef struct {
      carry_type car;
      per_type   per [3];
      per_type   mv [3];
   } p3_type;

   typedef struct {
      carry_type               car;
      logic signed [DEL_W-1:0] dva [3];
      logic signed [DEL_W-1:0] dvb [3];
      logic signed [DEL_W-1:0] dpa [3];
      logic signed [DEL_W-1:0] dpb [3];
   } p4_type;

   typedef struct {
      vec_type  vel_a;
      vec_type  vel_b;
      vec_type  pos_a;
      vec_type  pos_b;
      comp_type sep_sat;
      logic     vel_chg;
      logic     pos_chg;
   } out_type;

   function automatic comp_type get_comp(input vec_type v, input int idx);
      return comp_type'(v[idx*CW +: CW]);
   endfunction

   function automatic vec_type pack3(input comp_type x, input comp_type y, input comp_type z);
      return {z, y, x};
   endfunction

   function automatic comp_type sat_comp(input logic signed [63:0] x);
      if (x > CMAX64) begin
         return comp_type'(CMAX64);
      end else if (x < CMIN64) begin
         return comp_type'(CMIN64);
      end
      return comp_type'(x);
   endfunction

   function automatic per_type sat_per(input logic signed [63:0] x);
      if (x > PMAX64) begin
         return per_type'(PMAX64);
      end else if (x < PMIN64) begin
         return per_type'(PMIN64);
      end
      return per_type'(x);
   endfunction

   // One restoring step for both quotients: one quotient bit per stage.
   function automatic div_type div_step(input div_type d);
      logic [TW:0] tv;
      logic [TW:0] tp;
      div_type     r;
      r = d;
      tv = {d.rem_v, d.dq_v[DVD_W-1]};
      tp = {d.rem_p, d.dq_p[DVD_W-1]};
      if (tv >= {1'b0, d.tot}) begin
         r.rem_v = TW'(tv - {1'b0, d.tot});
         r.dq_v = {d.dq_v[DVD_W-2:0], 1'b1};
      end else begin
         r.rem_v = TW'(tv);
         r.dq_v = {d.dq_v[DVD_W-2:0], 1'b0};
      end
      if (tp >= {1'b0, d.tot}) begin
         r.rem_p = TW'(tp - {1'b0, d.tot});
         r.dq_p = {d.dq_p[DVD_W-2:0], 1'b1};
      end else begin
         r.rem_p = TW'(tp);
         r.dq_p = {d.dq_p[DVD_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> rtl/particle_contact_resolve.sv
// Particle contact resolver: one contact between particle A and an optional
// particle B per request, with velocities, accelerations, positions and the
// normal as three packed signed Q10.10 components (x in the low bits).
// A request is taken on the req_ channel when req_valid is high and req_stall
// is low; the result leaves on the rsp_ channel when rsp_valid is high and
// rsp_stall is low. The time step register is written through csr_write_enable
// and csr_write_data and should only change while no request is in flight.
// The request passes 59 register stages, and one request is taken every cycle
// unless the pipeline holds. The depth is set by the two quotients (impulse
// and penetration move), which come out of a pipelined restoring divider that
// resolves one quotient bit per stage over 47 stages.
// Reset clears every stage valid bit and returns the time step to 16.
// When the result register holds a result and the receiver stalls, the whole
// pipeline holds and req_stall is raised; nothing is dropped or repeated, and
// while rsp_valid is low the pipeline advances even when rsp_stall is high.
module particle_contact_resolve import pcr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [VW-1:0]        req_vel_a,
   input  logic [VW-1:0]        req_vel_b,
   input  logic [VW-1:0]        req_acc_a,
   input  logic [VW-1:0]        req_acc_b,
   input  logic [VW-1:0]        req_pos_a,
   input  logic [VW-1:0]        req_pos_b,
   input  logic [VW-1:0]        req_contact_normal,
   input  logic [MW-1:0]        req_inv_mass_a,
   input  logic [MW-1:0]        req_inv_mass_b,
   input  logic signed [CW-1:0] req_penetration_depth,
   input  logic [RW-1:0]        req_restitution,
   input  logic                 req_has_b,
   input  logic                 csr_write_enable,
   input  logic [MW-1:0]        csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VW-1:0]        rsp_new_vel_a,
   output logic [VW-1:0]        rsp_new_vel_b,
   output logic [VW-1:0]        rsp_new_pos_a,
   output logic [VW-1:0]        rsp_new_pos_b,
   output logic signed [CW-1:0] rsp_separating_velocity,
   output logic                 rsp_velocity_changed,
   output logic                 rsp_position_changed
);

   logic [MW-1:0]         time_step_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic                  adv;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   div_type div_head_in;
   div_type div_ff [DIV_STEPS+1];
   div_type div_in [DIV_STEPS+1];
   p1_type  p1_ff, p1_in;
   p2_type  p2_ff, p2_in;
   p3_type  p3_ff, p3_in;
   p4_type  p4_ff, p4_in;
   out_type out_ff, out_in;

   // The pipeline moves as one; it holds only while a finished result waits.
   assign adv       = !valid_ff[NUM_STAGES-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= MW'(16);
      end else if (csr_write_enable) begin
         time_step_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // Stage 1: relative velocity and acceleration, total inverse mass.
   always_comb begin
      comp_type va, vb, aa, ab;
      s1_in.car.vel_a      = req_vel_a;
      s1_in.car.vel_b      = req_vel_b;
      s1_in.car.pos_a      = req_pos_a;
      s1_in.car.pos_b      = req_pos_b;
      s1_in.car.normal     = req_contact_normal;
      s1_in.car.inv_mass_a = req_inv_mass_a;
      s1_in.car.inv_mass_b = req_has_b ? req_inv_mass_b : '0;
      s1_in.car.has_b      = req_has_b;
      s1_in.car.vel_chg    = 1'b0;
      s1_in.car.pos_chg    = 1'b0;
      s1_in.car.sep_sat    = '0;
      for (int i = 0; i < 3; i++) begin
         va = get_comp(req_vel_a, i);
         vb = get_comp(req_vel_b, i);
         aa = get_comp(req_acc_a, i);
         ab = get_comp(req_acc_b, i);
         s1_in.rv[i] = (CW+1)'(va) - (req_has_b ? (CW+1)'(vb) : '0);
         s1_in.ra[i] = (CW+1)'(aa) - (req_has_b ? (CW+1)'(ab) : '0);
      end
      s1_in.tot  = TW'(req_inv_mass_a) + (req_has_b ? TW'(req_inv_mass_b) : '0);
      s1_in.rest = req_restitution;
      s1_in.pen  = req_penetration_depth;
   end

   // Stage 2: per-axis products with the normal.
   always_comb begin
      comp_type n;
      s2_in.car  = s1_ff.car;
      s2_in.tot  = s1_ff.tot;
      s2_in.rest = s1_ff.rest;
      s2_in.pen  = s1_ff.pen;
      for (int i = 0; i < 3; i++) begin
         n = get_comp(s1_ff.car.normal, i);
         s2_in.pv[i] = s1_ff.rv[i] * n;
         s2_in.pq[i] = s1_ff.ra[i] * n;
      end
   end

   // Stage 3: dot products, separating velocity and the two enables.
   always_comb begin
      logic signed [DOT_W-1:0] dv, da;
      dv = DOT_W'(s2_ff.pv[0]) + DOT_W'(s2_ff.pv[1]) + DOT_W'(s2_ff.pv[2]);
      da = DOT_W'(s2_ff.pq[0]) + DOT_W'(s2_ff.pq[1]) + DOT_W'(s2_ff.pq[2]);
      s3_in.car  = s2_ff.car;
      s3_in.sep  = $signed(dv[DOT_W-1:FB]);
      s3_in.dota = $signed(da[DOT_W-1:FB]);
      s3_in.tot  = s2_ff.tot;
      s3_in.rest = s2_ff.rest;
      s3_in.pen  = s2_ff.pen;
      s3_in.car.vel_chg = (dv[DOT_W-1] || (dv[DOT_W-1:FB] == '0)) && (s2_ff.tot != '0);
      s3_in.car.pos_chg = (s2_ff.pen > $signed(CW'(0))) && (s2_ff.tot != '0);
   end

   // Stage 4: acceleration part times the time step, restitution target.
   always_comb begin
      logic [SEP_W-1:0]        negsep;
      logic [TGT_W+FB-1:0]     tp;
      negsep = SEP_W'(-s3_ff.sep);
      tp = negsep * s3_ff.rest;
      s4_in.car         = s3_ff.car;
      s4_in.car.sep_sat = sat_comp(64'(s3_ff.sep));
      s4_in.sep         = s3_ff.sep;
      s4_in.acc_prod    = s3_ff.dota * $signed({1'b0, time_step_ff});
      s4_in.tgt0        = tp[TGT_W+FB-1:FB];
      s4_in.tot         = s3_ff.tot;
      s4_in.rest        = s3_ff.rest;
      s4_in.pen         = s3_ff.pen;
   end

   // Stage 5: scale the acceleration part back to Q10.10.
   always_comb begin
      s5_in.car    = s4_ff.car;
      s5_in.sep    = s4_ff.sep;
      s5_in.accsep = $signed(s4_ff.acc_prod[ACP_W-1:FB]);
      s5_in.tgt0   = s4_ff.tgt0;
      s5_in.tot    = s4_ff.tot;
      s5_in.rest   = s4_ff.rest;
      s5_in.pen    = s4_ff.pen;
   end

   // Stage 6: restitution times the acceleration part.
   always_comb begin
      logic signed [RAD_W+FB-1:0] rp;
      rp = $signed({1'b0, s5_ff.rest}) * s5_ff.accsep;
      s6_in.car    = s5_ff.car;
      s6_in.sep    = s5_ff.sep;
      s6_in.accneg = s5_ff.accsep[ACC_W-1];
      s6_in.radd   = $signed(rp[RAD_W+FB-1:FB]);
      s6_in.tgt0   = s5_ff.tgt0;
      s6_in.tot    = s5_ff.tot;
      s6_in.pen    = s5_ff.pen;
   end

   // Stage 7: clamped target minus separating velocity, divider operands.
   always_comb begin
      logic signed [RAD_W+1:0] tsum;
      logic [TGT_W-1:0]        tcl;
      logic [NUM_W-1:0]        num;
      tsum = (RAD_W+2)'($signed({1'b0, s6_ff.tgt0}))
           + (s6_ff.accneg ? (RAD_W+2)'(s6_ff.radd) : '0);
      tcl  = tsum[RAD_W+1] ? '0 : tsum[TGT_W-1:0];
      num  = {1'b0, tcl} - NUM_W'(s6_ff.sep);
      div_head_in.car   = s6_ff.car;
      div_head_in.tot   = s6_ff.tot;
      div_head_in.rem_v = '0;
      div_head_in.rem_p = '0;
      div_head_in.dq_v  = {num, FB'(0)};
      div_head_in.dq_p  = DVD_W'({s6_ff.pen[CW-2:0], FB'(0)});
   end

   always_comb begin
      div_in[0] = div_head_in;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   // Back stage 1: the impulse saturates where every later product would.
   always_comb begin
      logic [DVD_W-1:0] qv, qp;
      qv = div_ff[DIV_STEPS].dq_v;
      qp = div_ff[DIV_STEPS].dq_p;
      p1_in.car = div_ff[DIV_STEPS].car;
      p1_in.imp = (qv[DVD_W-1:IMP_W] != '0) ? '1 : qv[IMP_W-1:0];
      p1_in.mpi = qp[MPI_W-1:0];
   end

   // Back stage 2: normal times impulse and times penetration move.
   always_comb begin
      comp_type n;
      p2_in.car = p1_ff.car;
      for (int i = 0; i < 3; i++) begin
         n = get_comp(p1_ff.car.normal, i);
         p2_in.prv[i] = n * $signed({1'b0, p1_ff.imp});
         p2_in.prp[i] = n * $signed({1'b0, p1_ff.mpi});
      end
   end

   // Back stage 3: scale and saturate. A 32-bit clamp already forces the
   // final component into saturation for any nonzero inverse mass.
   always_comb begin
      p3_in.car = p2_ff.car;
      for (int i = 0; i < 3; i++) begin
         p3_in.per[i] = sat_per(64'(p2_ff.prv[i]) >>> FB);
         p3_in.mv[i]  = sat_per(64'(p2_ff.prp[i]) >>> FB);
      end
   end

   // Back stage 4: weight by each particle's inverse mass.
   always_comb begin
      p4_in.car = p3_ff.car;
      for (int i = 0; i < 3; i++) begin
         p4_in.dva[i] = p3_ff.per[i] * $signed({1'b0, p3_ff.car.inv_mass_a});
         p4_in.dvb[i] = p3_ff.per[i] * $signed({1'b0, p3_ff.car.inv_mass_b});
         p4_in.dpa[i] = p3_ff.mv[i] * $signed({1'b0, p3_ff.car.inv_mass_a});
         p4_in.dpb[i] = p3_ff.mv[i] * $signed({1'b0, p3_ff.car.inv_mass_b});
      end
   end

   // Back stage 5: apply the changes with saturation into the result register.
   always_comb begin
      comp_type va [3], vb [3], pa [3], pb [3];
      carry_type c;
      c = p4_ff.car;
      for (int i = 0; i < 3; i++) begin
         va[i] = get_comp(c.vel_a, i);
         vb[i] = get_comp(c.vel_b, i);
         pa[i] = get_comp(c.pos_a, i);
         pb[i] = get_comp(c.pos_b, i);
         if (c.vel_chg) begin
            va[i] = sat_comp(64'(va[i]) + (64'(p4_ff.dva[i]) >>> FB));
            if (c.has_b) begin
               vb[i] = sat_comp(64'(vb[i]) - (64'(p4_ff.dvb[i]) >>> FB));
            end
         end
         if (c.pos_chg) begin
            pa[i] = sat_comp(64'(pa[i]) + (64'(p4_ff.dpa[i]) >>> FB));
            if (c.has_b) begin
               pb[i] = sat_comp(64'(pb[i]) - (64'(p4_ff.dpb[i]) >>> FB));
            end
         end
      end
      out_in.vel_a   = pack3(va[0], va[1], va[2]);
      out_in.vel_b   = pack3(vb[0], vb[1], vb[2]);
      out_in.pos_a   = pack3(pa[0], pa[1], pa[2]);
      out_in.pos_b   = pack3(pb[0], pb[1], pb[2]);
      out_in.sep_sat = c.sep_sat;
      out_in.vel_chg = c.vel_chg;
      out_in.pos_chg = c.pos_chg;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_ff[k] <= div_in[k];
         end
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
         out_ff <= out_in;
      end
   end

   assign rsp_new_vel_a           = out_ff.vel_a;
   assign rsp_new_vel_b           = out_ff.vel_b;
   assign rsp_new_pos_a           = out_ff.pos_a;
   assign rsp_new_pos_b           = out_ff.pos_b;
   assign rsp_separating_velocity = out_ff.sep_sat;
   assign rsp_velocity_changed    = out_ff.vel_chg;
   assign rsp_position_changed    = out_ff.pos_chg;

endmodule
